@@ rtl/glp_pkg.sv @@
package glp_pkg;

  localparam int unsigned POP_W      = 40;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned SHAPE_W    = 16;
  localparam int unsigned YEAR_OUT_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned RATE_FRAC  = 16;
  localparam int unsigned SHAPE_FRAC = 12;
  localparam int unsigned MANT_FRAC  = 30;
  localparam int unsigned MANT_W     = 32;
  localparam int unsigned MUL_AW     = 40;
  localparam int unsigned MUL_BW     = 32;
  localparam int unsigned MUL_PW     = MUL_AW + MUL_BW;
  localparam int unsigned GP_CAP_LOG = 42;

  localparam logic [POP_W-1:0] ONE_Q   = POP_W'(64'd65536);
  localparam logic [POP_W-1:0] POP_MAX = '1;
  localparam logic [63:0]      GP_CAP  = 64'd1 << GP_CAP_LOG;

  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPAC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITPOP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd5;

  typedef struct packed {
    logic [POP_W-1:0] year_catch;
    logic             restart;
  } glp_in_t;

  typedef struct packed {
    logic [POP_W-1:0]      population;
    logic [POP_W-1:0]      min_population;
    logic [YEAR_OUT_W-1:0] min_year;
    logic                  below_viable;
    logic                  is_minimum_year;
  } glp_out_t;

endpackage

@@ rtl/glp_mul.sv @@
module glp_mul (
  input  logic                        clk_i,
  input  logic [glp_pkg::MUL_AW-1:0]  a_i,
  input  logic [glp_pkg::MUL_BW-1:0]  b_i,
  output logic [glp_pkg::MUL_PW-1:0]  p_o
);
  import glp_pkg::*;

  logic [MUL_PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_PW'(a_i) * MUL_PW'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ rtl/generalized_logistic_projection.sv @@
// Generalized logistic population projection. Each accepted item carries one
// year's catch; the result (population at the start of that year, running
// minimum, its earliest year, viability flag) is registered right at accept,
// and the next population N + r*N*(1-(N/K)^z) - catch is then worked out on
// one shared 40x32 multiplier under a sequencer: two base-2 logarithms by
// repeated squaring, each after a load and normalization, one multiply for
// z*log2(N/K), one table multiply per set exponent fraction bit, and a final
// product with its shift. These steps are skipped when the growth term is
// zero. The input stalls until the next population is written, and while the
// output is stalled, so a new item is not taken before the last one is through.
// After reset the 2^(2^-i) table is built by bit-serial square roots
// (2*LOG_TABLE_BITS entries) before the first item is taken; configuration
// writes are taken at any time.
module generalized_logistic_projection #(
  parameter int unsigned LOG_TABLE_BITS = 8,
  parameter int unsigned YEAR_BITS      = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  glp_pkg::glp_in_t                 in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output glp_pkg::glp_out_t                out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [glp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [glp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import glp_pkg::*;

  localparam int unsigned LF   = 2 * LOG_TABLE_BITS;
  localparam int unsigned TIW  = $clog2(LF + 1);
  localparam int unsigned LGW  = 6 + LF;
  localparam int unsigned YSW  = ((YEAR_BITS > YEAR_OUT_W) ? YEAR_BITS : YEAR_OUT_W) + 1;

  localparam logic [3:0] S_TAB   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_G     = 4'd2;
  localparam logic [3:0] S_GRES  = 4'd3;
  localparam logic [3:0] S_LINIT = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_SQRES = 4'd7;
  localparam logic [3:0] S_ZMUL  = 4'd8;
  localparam logic [3:0] S_ZRES  = 4'd9;
  localparam logic [3:0] S_EXP   = 4'd10;
  localparam logic [3:0] S_EXRES = 4'd11;
  localparam logic [3:0] S_TT    = 4'd12;
  localparam logic [3:0] S_TTRES = 4'd13;
  localparam logic [3:0] S_UPD   = 4'd14;

  logic [3:0] state_q;

  // configuration
  logic [RATE_W-1:0]     r_q;
  logic [POP_W-1:0]      k_q;
  logic [SHAPE_W-1:0]    z_q;
  logic [POP_W-1:0]      init_q;
  logic [POP_W-1:0]      viable_q;
  logic [YEAR_OUT_W-1:0] start_q;

  // projection state
  logic [POP_W-1:0]     n_q, low_q;
  logic [YEAR_BITS-1:0] yidx_q, lowyidx_q;

  // working registers
  logic [POP_W-1:0]      g_q, catch_q, x_q;
  logic [5:0]            e_q;
  logic [MANT_W-1:0]     m_q;
  logic [LF-1:0]         fr_q, ef_q;
  logic [TIW-1:0]        cnt_q;
  logic [LGW-1:0]        lgn_q, dmag_q;
  logic                  dneg_q, which_q;
  logic signed [47:0]    u_q;
  logic [GP_CAP_LOG:0]   gp_q;

  // table build
  logic [MANT_W-2:0] tab_q [1:LF];
  logic [63:0]       tx_q, tres_q;
  logic [4:0]        tcnt_q;
  logic [TIW-1:0]    tidx_q;

  logic              out_valid_q;
  glp_out_t          out_q;

  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;

  glp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_G: begin
        mul_a = n_q;
        mul_b = MUL_BW'(r_q);
      end
      S_SQ: begin
        mul_a = MUL_AW'(m_q);
        mul_b = m_q;
      end
      S_ZMUL: begin
        mul_a = MUL_AW'(dmag_q);
        mul_b = MUL_BW'(z_q);
      end
      S_EXP: begin
        mul_a = MUL_AW'(m_q);
        mul_b = MUL_BW'(tab_q[cnt_q]);
      end
      S_TT: begin
        mul_a = g_q;
        mul_b = MUL_BW'(m_q >> 10);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic accept;
  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // accept-time result
  logic [POP_W-1:0]     a_n, a_lw, a_low;
  logic [YEAR_BITS-1:0] a_yi, a_lyi;
  logic                 a_upd;
  logic [YSW-1:0]       a_ysum;
  always_comb begin
    a_n    = in_item_i.restart ? init_q : n_q;
    a_yi   = in_item_i.restart ? '0 : yidx_q;
    a_lw   = in_item_i.restart ? POP_MAX : low_q;
    a_upd  = (a_yi == '0) || (a_n < a_lw);
    a_low  = a_upd ? a_n : a_lw;
    a_lyi  = a_upd ? a_yi : lowyidx_q;
    a_ysum = YSW'(start_q) + YSW'(a_lyi);
  end

  // table square root step
  logic [63:0] t_bit, t_sum, t_x, t_res;
  always_comb begin
    t_bit = 64'd1 << {tcnt_q, 1'b0};
    t_sum = tres_q + t_bit;
    if (tx_q >= t_sum) begin
      t_x   = tx_q - t_sum;
      t_res = (tres_q >> 1) + t_bit;
    end else begin
      t_x   = tx_q;
      t_res = tres_q >> 1;
    end
  end

  // log squaring step
  logic [MANT_W-1:0] sq;
  logic [LF-1:0]     fr_n;
  logic [MANT_W-1:0] m_n;
  logic [LGW-1:0]    lg;
  logic [LGW:0]      dsum;
  always_comb begin
    sq   = mul_p[MANT_FRAC +: MANT_W];
    m_n  = sq[MANT_W-1] ? (sq >> 1) : sq;
    fr_n = {fr_q[LF-2:0], sq[MANT_W-1]};
    lg   = {e_q, fr_n};
    dsum = {1'b0, lgn_q} - {1'b0, lg};
  end

  // exponent split
  logic [47:0]        zmag, zq;
  logic signed [47:0] u_n, ip, sh, nsh;
  always_comb begin
    zmag = mul_p[47:0];
    zq   = dneg_q ? ((zmag + 48'd4095) >> SHAPE_FRAC) : (zmag >> SHAPE_FRAC);
    u_n  = dneg_q ? -$signed(zq) : $signed(zq);
    ip   = u_q >>> LF;
    sh   = 48'sd20 - ip;
    nsh  = -sh;
  end

  // density term scaling
  logic [63:0]         tt, capsh, tsh;
  logic [GP_CAP_LOG:0] gp_n;
  always_comb begin
    tt    = 64'(mul_p[60:0]);
    capsh = GP_CAP >> nsh[4:0];
    tsh   = tt >> sh[5:0];
    if (sh >= 48'sd0) begin
      if (sh >= 48'sd63)     gp_n = '0;
      else if (tsh > GP_CAP) gp_n = (GP_CAP_LOG+1)'(GP_CAP);
      else                   gp_n = (GP_CAP_LOG+1)'(tsh);
    end else if (nsh >= 48'sd21 || tt > capsh) begin
      gp_n = (GP_CAP_LOG+1)'(GP_CAP);
    end else begin
      gp_n = (GP_CAP_LOG+1)'(tt << nsh[4:0]);
    end
  end

  // next population
  logic signed [46:0] nx;
  logic [POP_W-1:0]   n_next;
  always_comb begin
    nx = $signed({7'd0, n_q}) + $signed({7'd0, g_q}) - $signed({4'd0, gp_q})
       - $signed({7'd0, catch_q});
    if (nx < $signed({7'd0, ONE_Q}))        n_next = ONE_Q;
    else if (nx > $signed({7'd0, POP_MAX})) n_next = POP_MAX;
    else                                    n_next = nx[POP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q         <= '0;
      k_q         <= POP_W'(64'd65536000);
      z_q         <= SHAPE_W'(16'd9789);
      init_q      <= POP_W'(64'd65536000);
      viable_q    <= '0;
      start_q     <= '0;
      n_q         <= POP_W'(64'd65536000);
      low_q       <= POP_MAX;
      yidx_q      <= '0;
      lowyidx_q   <= '0;
      state_q     <= S_TAB;
      out_valid_q <= 1'b0;
      tx_q        <= 64'd1 << 61;
      tres_q      <= '0;
      tcnt_q      <= 5'd31;
      tidx_q      <= TIW'(1);
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GROWTH:  r_q      <= cfg_data_i[RATE_W-1:0];
          CFG_CAPAC:   k_q      <= cfg_data_i[POP_W-1:0];
          CFG_SHAPE:   z_q      <= cfg_data_i[SHAPE_W-1:0];
          CFG_INITPOP: init_q   <= cfg_data_i[POP_W-1:0];
          CFG_VIABLE:  viable_q <= cfg_data_i[POP_W-1:0];
          CFG_START:   start_q  <= cfg_data_i[YEAR_OUT_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_TAB: begin
          if (tcnt_q == 5'd0) begin
            tab_q[tidx_q] <= t_res[MANT_W-2:0];
            tx_q          <= 64'(t_res[MANT_W-2:0]) << MANT_FRAC;
            tres_q        <= '0;
            tcnt_q        <= 5'd31;
            tidx_q        <= tidx_q + TIW'(1);
            if (tidx_q == TIW'(LF)) state_q <= S_IDLE;
          end else begin
            tx_q   <= t_x;
            tres_q <= t_res;
            tcnt_q <= tcnt_q - 5'd1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            n_q                  <= a_n;
            yidx_q               <= a_yi;
            low_q                <= a_low;
            lowyidx_q            <= a_lyi;
            catch_q              <= in_item_i.year_catch;
            which_q              <= 1'b0;
            out_q.population     <= a_n;
            out_q.min_population <= a_low;
            out_q.min_year       <= (a_ysum > YSW'({YEAR_OUT_W{1'b1}})) ?
                                    '1 : a_ysum[YEAR_OUT_W-1:0];
            out_q.below_viable    <= a_low < viable_q;
            out_q.is_minimum_year <= a_n == a_low;
            state_q              <= S_G;
          end
        end
        S_G: state_q <= S_GRES;
        S_GRES: begin
          g_q <= mul_p[RATE_FRAC +: POP_W];
          if (mul_p[RATE_FRAC +: POP_W] == '0 || n_q == '0) begin
            gp_q    <= '0;
            state_q <= S_UPD;
          end else begin
            state_q <= S_LINIT;
          end
        end
        S_LINIT: begin
          x_q     <= which_q ? ((k_q == '0) ? POP_W'(1) : k_q) : n_q;
          e_q     <= 6'd39;
          state_q <= S_NORM;
        end
        S_NORM: begin
          if (x_q[POP_W-1]) begin
            m_q     <= {1'b0, x_q[POP_W-1 -: MANT_W-1]};
            fr_q    <= '0;
            cnt_q   <= '0;
            state_q <= S_SQ;
          end else if (x_q[POP_W-1 -: 8] == 8'd0) begin
            x_q <= x_q << 8;
            e_q <= e_q - 6'd8;
          end else begin
            x_q <= x_q << 1;
            e_q <= e_q - 6'd1;
          end
        end
        S_SQ: state_q <= S_SQRES;
        S_SQRES: begin
          m_q   <= m_n;
          fr_q  <= fr_n;
          cnt_q <= cnt_q + TIW'(1);
          if (cnt_q == TIW'(LF - 1)) begin
            if (!which_q) begin
              lgn_q   <= lg;
              which_q <= 1'b1;
              state_q <= S_LINIT;
            end else begin
              dneg_q  <= dsum[LGW];
              dmag_q  <= dsum[LGW] ? LGW'(-dsum) : dsum[LGW-1:0];
              state_q <= S_ZMUL;
            end
          end else begin
            state_q <= S_SQ;
          end
        end
        S_ZMUL: state_q <= S_ZRES;
        S_ZRES: begin
          u_q     <= u_n;
          ef_q    <= u_n[LF-1:0];
          m_q     <= MANT_W'(64'd1 << MANT_FRAC);
          cnt_q   <= TIW'(1);
          state_q <= S_EXP;
        end
        S_EXP: begin
          if (ef_q[LF-1]) begin
            state_q <= S_EXRES;
          end else begin
            ef_q  <= ef_q << 1;
            cnt_q <= cnt_q + TIW'(1);
            if (cnt_q == TIW'(LF)) state_q <= S_TT;
          end
        end
        S_EXRES: begin
          m_q   <= sq;
          ef_q  <= ef_q << 1;
          cnt_q <= cnt_q + TIW'(1);
          state_q <= (cnt_q == TIW'(LF)) ? S_TT : S_EXP;
        end
        S_TT: state_q <= S_TTRES;
        S_TTRES: begin
          gp_q    <= gp_n;
          state_q <= S_UPD;
        end
        S_UPD: begin
          n_q <= n_next;
          if (yidx_q != '1) yidx_q <= yidx_q + YEAR_BITS'(1);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  import glp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST   = 3'd7;
  localparam int LOG_FRAC   = 16;
  localparam int SETTLE     = 250;
  localparam int STALL_CAP  = 20000;
  localparam logic [63:0] MASK40 = 64'hFF_FFFF_FFFF;

  class projection_board;
    logic [63:0] pow_tab [0:LOG_FRAC];
    logic [63:0] rate, capac, shape, init_pop, viable, first_year;
    logic [63:0] cur_pop, low_pop, yr_idx, low_idx;
    glp_out_t    expected_q[$];
    int          errors;
    int          checked;
    int          restarts;
    int          min_hits;

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function new();
      pow_tab[0] = 64'd2 << 30;
      pow_tab[1] = int_sqrt(64'd1 << 61);
      for (int i = 2; i <= LOG_FRAC; i++) pow_tab[i] = int_sqrt(pow_tab[i-1] << 30);
      rate = 0; capac = 65536000; shape = 9789; init_pop = 65536000;
      viable = 0; first_year = 0;
      cur_pop = init_pop; low_pop = MASK40; yr_idx = 0; low_idx = 0;
      errors = 0; checked = 0; restarts = 0; min_hits = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
      case (idx)
        CFG_GROWTH:  rate = v & 64'hFFFF;
        CFG_CAPAC:   capac = v & MASK40;
        CFG_SHAPE:   shape = v & 64'hFFFF;
        CFG_INITPOP: init_pop = v & MASK40;
        CFG_VIABLE:  viable = v & MASK40;
        CFG_START:   first_year = v & 64'hFFFF;
        default: ;
      endcase
    endfunction

    function automatic longint log2_fixed(logic [63:0] x);
      int e;
      logic [63:0] m, fr;
      e = 63;
      fr = 0;
      while (e > 0 && !x[e]) e--;
      m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
      for (int i = 0; i < LOG_FRAC; i++) begin
        m = (m * m) >> 30;
        fr = fr << 1;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          fr = fr | 1;
        end
      end
      return longint'(e) * 65536 + longint'(fr);
    endfunction

    function automatic logic [63:0] density(logic [63:0] n, logic [63:0] g);
      logic [63:0] k, m, fr, tt;
      longint d, t, u, ip, sh;
      k = (capac != 0) ? capac : 64'd1;
      m = 64'd1 << 30;
      if (n == 0 || g == 0) return 0;
      d = log2_fixed(n) - log2_fixed(k);
      t = longint'(shape) * d;
      u = t >>> 12;
      ip = u >>> LOG_FRAC;
      fr = u - ip * 65536;
      for (int i = 1; i <= LOG_FRAC; i++)
        if (fr[LOG_FRAC-i]) m = (m * pow_tab[i]) >> 30;
      tt = g * (m >> 10);
      sh = 20 - ip;
      if (sh >= 0) return (sh >= 63) ? 64'd0 : (tt >> sh);
      sh = -sh;
      if (sh >= 21 || tt > (GP_CAP >> sh)) return GP_CAP;
      return tt << sh;
    endfunction

    function void note_item(glp_in_t it);
      glp_out_t exp_r;
      logic [63:0] n, g, gp, yr;
      longint nx;
      if (it.restart) begin
        cur_pop = init_pop; yr_idx = 0; low_pop = MASK40;
        restarts++;
      end
      n = cur_pop;
      if (yr_idx == 0 || n < low_pop) begin
        low_pop = n;
        low_idx = yr_idx;
      end
      yr = first_year + low_idx;
      if (yr > 64'hFFFF) yr = 64'hFFFF;
      exp_r.population = n[39:0];
      exp_r.min_population = low_pop[39:0];
      exp_r.min_year = yr[15:0];
      exp_r.below_viable = low_pop < viable;
      exp_r.is_minimum_year = n == low_pop;
      expected_q = {expected_q, exp_r};
      g = (rate * n) >> 16;
      gp = density(n, g);
      nx = longint'(n) + longint'(g) - longint'(gp) - longint'(it.year_catch);
      if (nx < longint'(ONE_Q)) cur_pop = ONE_Q;
      else if (nx > longint'(MASK40)) cur_pop = MASK40;
      else cur_pop = nx;
      if (yr_idx < 64'hFFFF) yr_idx++;
    endfunction

    task report(string what);
      $display("mismatch at result %0d: %s", checked, what);
      errors++;
    endtask

    task check_result(glp_out_t got);
      glp_out_t e;
      if (expected_q.size() == 0) begin
        report("unexpected item");
        return;
      end
      e = expected_q.pop_front();
      if (got.population != e.population)
        report($sformatf("population %h vs %h", got.population, e.population));
      if (got.min_population != e.min_population)
        report($sformatf("min_population %h vs %h", got.min_population, e.min_population));
      if (got.min_year != e.min_year)
        report($sformatf("min_year %0d vs %0d", got.min_year, e.min_year));
      if (got.below_viable != e.below_viable)
        report($sformatf("below_viable %b vs %b", got.below_viable, e.below_viable));
      if (got.is_minimum_year != e.is_minimum_year)
        report($sformatf("is_minimum_year %b vs %b", got.is_minimum_year,
                         e.is_minimum_year));
      if (got.is_minimum_year) min_hits++;
      checked++;
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  glp_in_t in_item;
  glp_out_t out_item;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  projection_board board;
  int idle_cycles;
  int gap_mode;

  generalized_logistic_projection DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_mode == 0) return 0;
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [39:0] rand_catch();
    logic [39:0] v;
    v = 40'({$urandom, $urandom});
    return v >> $urandom_range(0, 40);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) board.check_result(out_item);
      out_stall <= (gap_mode != 0) && ($urandom_range(0, 99) < 30) &&
                   ($urandom_range(0, 9) != 0 || $urandom_range(0, 3) == 0);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= STALL_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [39:0] catch_v, logic rs);
    glp_in_t it;
    int gap;
    it.year_catch = catch_v;
    it.restart = rs;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    board.note_item(it);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [39:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_all(logic [39:0] r, logic [39:0] k, logic [39:0] z,
                         logic [39:0] n0, logic [39:0] vm, logic [39:0] sy);
    write_cfg(CFG_GROWTH, r);
    write_cfg(CFG_CAPAC, k);
    write_cfg(CFG_SHAPE, z);
    write_cfg(CFG_INITPOP, n0);
    write_cfg(CFG_VIABLE, vm);
    write_cfg(CFG_START, sy);
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) gap_mode = $urandom_range(0, 3);
      send_item(rand_catch(), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GROWTH;
    cfg_data = '0;
    gap_mode = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration, directed items
    send_item(40'd0, 1'b0);
    send_item(40'd0, 1'b0);
    send_item('1, 1'b0);
    send_item(40'd0, 1'b1);
    send_item(40'd65536, 1'b0);
    settle();
    set_all(40'd65535, 40'd65536000, 40'd9789, 40'd65536000, 40'd32768000, 40'd2000);
    write_cfg(CFG_UNUSED, '1);
    write_cfg(CFG_LAST, 40'd12345);
    send_item(40'd0, 1'b1);
    for (int i = 0; i < 6; i++) send_item(40'd0, 1'b0);
    send_item(40'd1000000000, 1'b0);
    send_item(40'd0, 1'b0);
    send_item('1, 1'b0);
    send_item(40'd0, 1'b0);
    random_run(140);
    settle();

    // zero capacity, smallest shape, years past the top
    set_all(40'd30000, 40'd0, 40'd1, 40'd655360, '1, 40'd65530);
    send_item(40'd0, 1'b1);
    random_run(150);
    settle();

    // largest settings, with a zero viability threshold
    set_all(40'd65535, '1, 40'd65535, '1, 40'd0, 40'd65535);
    send_item(40'd0, 1'b1);
    for (int i = 0; i < 4; i++) send_item(40'd0, 1'b0);
    random_run(150);
    settle();

    // zero initial population, capacity of one
    set_all(40'd20000, 40'd65536, 40'd4096, 40'd0, 40'd65536, 40'd100);
    send_item(40'd0, 1'b1);
    send_item(40'd0, 1'b0);
    random_run(150);
    settle();

    // no growth
    set_all(40'd0, 40'd6553600, 40'd2048, 40'd655360000, 40'd600000000, 40'd1);
    send_item(40'd0, 1'b1);
    random_run(120);
    settle();

    for (int p = 0; p < 3; p++) begin
      set_all(40'($urandom_range(0, 65535)), 40'({$urandom, $urandom}),
              40'($urandom_range(1, 65535)),
              40'({$urandom, $urandom}) >> $urandom_range(0, 20),
              40'({$urandom, $urandom}) >> $urandom_range(0, 20),
              40'($urandom_range(0, 65535)));
      send_item(40'd0, 1'b1);
      random_run(60);
      settle();
    end

    $display("projection run: %0d years checked, %0d restarts, %0d minimum years seen",
             board.checked, board.restarts, board.min_hits);
    $display("covered reset, extreme and random settings of all six registers");
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
